[rtl/sid_pkg.sv]
package sid_pkg;

	// Operand and result word width
	localparam int unsigned WORD_W = 32;

	// Most negative operand, minus one, and the saturated result
	localparam logic [WORD_W-1:0] MIN_NEG  = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] MINUS_1  = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] SAT_MAX  = {1'b0, {(WORD_W-1){1'b1}}};

	// Work carried down the division pipe
	typedef struct packed {
		logic [WORD_W-1:0] rem;   // partial remainder, below the divisor unless the divisor is zero
		logic [WORD_W-1:0] num;   // dividend magnitude, next bit at the top
		logic [WORD_W-1:0] dvs;   // divisor magnitude
		logic [WORD_W-1:0] quo;   // quotient bits found so far
		logic              neg;   // result takes a minus sign
		logic              sat;   // result saturates
	} work_t;

endpackage

[rtl/sid_if.sv]
// Operand channel: one beat carries a dividend and a divisor
interface sid_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [sid_pkg::WORD_W-1:0] numerator;
	logic signed [sid_pkg::WORD_W-1:0] denominator;

	modport source (output valid, output numerator, output denominator, input ready);
	modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// Result channel: one beat carries a quotient
interface sid_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [sid_pkg::WORD_W-1:0] quotient;

	modport source (output valid, output quotient, input ready);
	modport sink   (input valid, input quotient, output ready);
endinterface

[rtl/sid_prep.sv]
module sid_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid,
	input  logic [sid_pkg::WORD_W-1:0]    numerator,
	input  logic [sid_pkg::WORD_W-1:0]    denominator,
	output logic                          valid_s1,
	output sid_pkg::work_t                work_s1
);

	sid_pkg::work_t work_d;

	// Take magnitudes, sign and the saturating cases
	always_comb begin
		work_d.rem = '0;
		work_d.quo = '0;
		work_d.num = numerator[sid_pkg::WORD_W-1] ? (~numerator + 1'b1) : numerator;
		work_d.dvs = denominator[sid_pkg::WORD_W-1] ? (~denominator + 1'b1) : denominator;
		work_d.neg = numerator[sid_pkg::WORD_W-1] ^ denominator[sid_pkg::WORD_W-1];
		work_d.sat = (denominator == '0) ||
			((numerator == sid_pkg::MIN_NEG) && (denominator == sid_pkg::MINUS_1));
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_d;
		end
	end

endmodule

[rtl/sid_step.sv]
module sid_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid,
	input  sid_pkg::work_t work,
	output logic           valid_s1,
	output sid_pkg::work_t work_s1
);

	logic [sid_pkg::WORD_W:0]   trial;
	logic [sid_pkg::WORD_W:0]   diff;
	logic                       fits;
	sid_pkg::work_t             work_d;

	// Bring down the next dividend bit and try to subtract the divisor
	always_comb begin
		trial      = {work.rem, work.num[sid_pkg::WORD_W-1]};
		diff       = trial - {1'b0, work.dvs};
		fits       = ~diff[sid_pkg::WORD_W];
		work_d     = work;
		work_d.rem = fits ? diff[sid_pkg::WORD_W-1:0] : trial[sid_pkg::WORD_W-1:0];
		work_d.num = {work.num[sid_pkg::WORD_W-2:0], 1'b0};
		work_d.quo = {work.quo[sid_pkg::WORD_W-2:0], fits};
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_d;
		end
	end

endmodule

[rtl/sid_post.sv]
module sid_post (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid,
	input  sid_pkg::work_t             work,
	output logic                       valid_q,
	output logic [sid_pkg::WORD_W-1:0] quotient_q
);

	logic [sid_pkg::WORD_W-1:0] quotient_d;

	// Apply the sign, or saturate
	always_comb begin
		if (work.sat) begin
			quotient_d = sid_pkg::SAT_MAX;
		end else if (work.neg) begin
			quotient_d = ~work.quo + 1'b1;
		end else begin
			quotient_d = work.quo;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_q <= quotient_d;
		end
	end

endmodule

[rtl/signed_integer_divider_core.sv]
// Signed 32-bit integer divider, quotient truncated toward zero.
//
// Channels: operands (sink) carries numerator and denominator; result
// (source) carries quotient. A beat moves on a clock edge with valid and
// ready both high. A zero denominator, or the most negative numerator over
// minus one, gives 0x7FFFFFFF.
//
// Pipeline: the quotient of an operand beat is formed in one stage for
// magnitudes and sign, one stage for each of the 32 restoring
// shift-and-subtract steps (one quotient bit each), and the output
// register that applies the sign and drives result.
// Throughput: one beat per cycle while result is taken.
//
// Reset (arst_n low) clears every stage's valid bit at once; beats in
// flight are dropped. When the receiver holds ready low with a result
// waiting, the whole pipe freezes and operands.ready falls; nothing is
// lost or repeated.
module signed_integer_divider_core (
	input  logic      clk,
	input  logic      arst_n,
	sid_in_if.sink    operands,
	sid_out_if.source result
);

	localparam int unsigned STEPS = sid_pkg::WORD_W;

	logic           en;
	logic           out_valid_q;
	logic           stage_valid [0:STEPS];
	sid_pkg::work_t stage_work  [0:STEPS];

	// Advance the pipe whenever the output register is free or being emptied
	assign en             = ~out_valid_q | result.ready;
	assign operands.ready = en;

	sid_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid       (operands.valid),
		.numerator   (operands.numerator),
		.denominator (operands.denominator),
		.valid_s1    (stage_valid[0]),
		.work_s1     (stage_work[0])
	);

	// One quotient bit per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		sid_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (stage_valid[i]),
			.work     (stage_work[i]),
			.valid_s1 (stage_valid[i+1]),
			.work_s1  (stage_work[i+1])
		);
	end

	sid_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (stage_valid[STEPS]),
		.work       (stage_work[STEPS]),
		.valid_q    (out_valid_q),
		.quotient_q (result.quotient)
	);

	assign result.valid = out_valid_q;

endmodule
